FILE: src/ppd_pkg.sv
// Shared constants, codes and control types of the preamble detector and symbol slicer.
package ppd_pkg;

   // Defaults for the top-level parameters
   localparam int REF_LEN_DEFAULT     = 63;
   localparam int SAMPLE_BITS_DEFAULT = 12;

   // Fixed field widths
   localparam int COEF_INDEX_BITS = 6;
   localparam int THRESHOLD_BITS  = 8;
   localparam int CP_BITS         = 11;
   localparam int SC_BITS         = 13;
   localparam int SPF_BITS        = 4;
   localparam int SYM_BITS        = 4;
   localparam int SUB_BITS        = 12;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 13;
   localparam int TT_BITS         = 2 * THRESHOLD_BITS;

   // Register reset values
   localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 8'd179;
   localparam logic [CP_BITS-1:0]        CP_RESET        = 11'd16;
   localparam logic [SC_BITS-1:0]        SC_RESET        = 13'd64;
   localparam logic [SPF_BITS-1:0]       SPF_RESET       = 4'd7;

   // Largest usable subcarrier count
   localparam logic [SC_BITS-1:0] SC_MAX = 13'd4096;

   // Q0.8 squared against a 16-bit left shift of |C|^2
   localparam int SCALE_SHIFT = 16;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_CP        = 2'd1,
      CSR_SC        = 2'd2,
      CSR_SPF       = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_COEF   = 1'b1
   } op_type;

   typedef enum logic {
      KIND_DETECT = 1'b0,
      KIND_DATA   = 1'b1
   } kind_type;

   // Top level to correlator
   typedef struct packed {
      logic shift;
      logic start;
      logic coef_we;
   } ctrl_type;

   // Correlator to top level
   typedef struct packed {
      logic done;
      logic hit;
   } stat_type;

endpackage

FILE: src/ppd_if.sv
// Request and response channel interfaces of the preamble detector.
interface ppd_req_if #(
   parameter int SAMPLE_BITS = ppd_pkg::SAMPLE_BITS_DEFAULT
) ();
   logic                                 valid;
   logic                                 ready;
   logic                                 operation;
   logic signed [SAMPLE_BITS-1:0]        sample_re;
   logic signed [SAMPLE_BITS-1:0]        sample_im;
   logic [ppd_pkg::COEF_INDEX_BITS-1:0]  coef_index;
   logic signed [SAMPLE_BITS-1:0]        coef_re;
   logic signed [SAMPLE_BITS-1:0]        coef_im;

   modport source (output valid, operation, sample_re, sample_im, coef_index, coef_re, coef_im,
                   input ready);
   modport sink (input valid, operation, sample_re, sample_im, coef_index, coef_re, coef_im,
                 output ready);
endinterface

interface ppd_rsp_if #(
   parameter int SAMPLE_BITS = ppd_pkg::SAMPLE_BITS_DEFAULT
) ();
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [ppd_pkg::SYM_BITS-1:0]  symbol_index;
   logic [ppd_pkg::SUB_BITS-1:0]  subcarrier_index;
   logic signed [SAMPLE_BITS-1:0] out_re;
   logic signed [SAMPLE_BITS-1:0] out_im;
   logic                          last_in_symbol;
   logic                          last_in_frame;

   modport source (output valid, kind, symbol_index, subcarrier_index, out_re, out_im,
                   last_in_symbol, last_in_frame, input ready);
   modport sink (input valid, kind, symbol_index, subcarrier_index, out_re, out_im,
                 last_in_symbol, last_in_frame, output ready);
endinterface

FILE: src/ppd_cell.sv
// One correlator cell: a window sample and a reference coefficient, passed along the ring.
module ppd_cell #(
   parameter int SAMPLE_BITS = ppd_pkg::SAMPLE_BITS_DEFAULT,
   parameter int INDEX       = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift_en,
   input  logic                                rot_en,
   input  logic                                coef_we,
   input  logic [ppd_pkg::COEF_INDEX_BITS-1:0] coef_index,
   input  logic [2*SAMPLE_BITS-1:0]            coef_wr,
   input  logic [2*SAMPLE_BITS-1:0]            win_next,
   input  logic [2*SAMPLE_BITS-1:0]            cof_next,
   output logic [2*SAMPLE_BITS-1:0]            win_q,
   output logic [2*SAMPLE_BITS-1:0]            cof_q
);

   logic [2*SAMPLE_BITS-1:0] win_ff, win_in;
   logic [2*SAMPLE_BITS-1:0] cof_ff, cof_in;

   // window takes the neighbor value on a shift or a rotation
   always_comb begin
      win_in = (shift_en || rot_en) ? win_next : win_ff;
      if (rot_en) begin
         cof_in = cof_next;
      end else if (coef_we && (int'(coef_index) == INDEX)) begin
         cof_in = coef_wr;
      end else begin
         cof_in = cof_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in;
      end
   end

   // reference entry has no reset value
   always_ff @(posedge clock) begin
      cof_ff <= cof_in;
   end

   assign win_q = win_ff;
   assign cof_q = cof_ff;

endmodule

FILE: src/ppd_corr.sv
// Cell ring with a multiply-accumulate head and the normalized threshold compare.
module ppd_corr #(
   parameter int REF_LEN     = ppd_pkg::REF_LEN_DEFAULT,
   parameter int SAMPLE_BITS = ppd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ppd_pkg::ctrl_type                   ctrl,
   input  logic signed [SAMPLE_BITS-1:0]       sample_re,
   input  logic signed [SAMPLE_BITS-1:0]       sample_im,
   input  logic [ppd_pkg::COEF_INDEX_BITS-1:0] coef_index,
   input  logic signed [SAMPLE_BITS-1:0]       coef_re,
   input  logic signed [SAMPLE_BITS-1:0]       coef_im,
   input  logic [ppd_pkg::THRESHOLD_BITS-1:0]  threshold,
   output ppd_pkg::stat_type                   stat
);

   localparam int SB   = SAMPLE_BITS;
   localparam int PW   = 2 * SB;
   localparam int CNTW = $clog2(REF_LEN);
   localparam int CW   = 2 * SB + 1 + CNTW;
   localparam int CMPW = 2 * CW + 1 + ppd_pkg::SCALE_SHIFT;
   localparam int RPW  = CW + ppd_pkg::TT_BITS;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SWEEP,
      CS_DRAIN,
      CS_SQ,
      CS_SCALE,
      CS_CMP
   } cstate_type;

   cstate_type state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic pv_ff, pv_in;

   logic [PW-1:0] win_q [REF_LEN];
   logic [PW-1:0] cof_q [REF_LEN];
   logic [PW-1:0] win_nx [REF_LEN];
   logic [PW-1:0] cof_nx [REF_LEN];
   logic rot;

   assign rot = (state_ff == CS_SWEEP);

   // ring of cells; the tail takes new samples on a shift and the head on a rotation
   for (genvar i = 0; i < REF_LEN; i++) begin : g_cell
      if (i == REF_LEN - 1) begin : g_tail
         assign win_nx[i] = ctrl.shift ? {sample_re, sample_im} : win_q[0];
         assign cof_nx[i] = cof_q[0];
      end else begin : g_body
         assign win_nx[i] = win_q[i+1];
         assign cof_nx[i] = cof_q[i+1];
      end
      ppd_cell #(.SAMPLE_BITS(SB), .INDEX(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (ctrl.shift),
         .rot_en     (rot),
         .coef_we    (ctrl.coef_we),
         .coef_index (coef_index),
         .coef_wr    ({coef_re, coef_im}),
         .win_next   (win_nx[i]),
         .cof_next   (cof_nx[i]),
         .win_q      (win_q[i]),
         .cof_q      (cof_q[i])
      );
   end

   // head cell operands
   logic signed [SB-1:0] xr, xi, rr, ri;
   assign xr = win_q[0][PW-1:SB];
   assign xi = win_q[0][SB-1:0];
   assign rr = cof_q[0][PW-1:SB];
   assign ri = cof_q[0][SB-1:0];

   // product stage
   logic signed [PW-1:0] p_xrrr_ff, p_xiri_ff, p_xirr_ff, p_xrri_ff;
   logic signed [PW-1:0] p_xrxr_ff, p_xixi_ff, p_rrrr_ff, p_riri_ff;

   // accumulators and final stages
   logic signed [CW-1:0] cre_ff, cre_in, cim_ff, cim_in, ex_ff, ex_in, er_ff, er_in;
   logic [CW-1:0]        mag_re, mag_im;
   logic [2*CW-1:0]      cre2_ff, cim2_ff, exer_ff;
   logic [ppd_pkg::TT_BITS-1:0] tt_ff;
   logic                 zero_ff;
   logic [CMPW-1:0]      lhs_ff;
   logic [RPW-1:0]       rlo_ff, rhi_ff;
   logic [CMPW-1:0]      rhs;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pv_in    = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            cnt_in = '0;
            if (ctrl.start) begin
               state_in = CS_SWEEP;
            end
         end
         CS_SWEEP: begin
            pv_in  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNTW'(REF_LEN - 1)) begin
               state_in = CS_DRAIN;
            end
         end
         CS_DRAIN: state_in = CS_SQ;
         CS_SQ:    state_in = CS_SCALE;
         CS_SCALE: state_in = CS_CMP;
         CS_CMP:   state_in = CS_IDLE;
         default:  state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         cnt_ff   <= '0;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
      end
   end

   // accumulate the registered head products
   always_comb begin
      cre_in = cre_ff;
      cim_in = cim_ff;
      ex_in  = ex_ff;
      er_in  = er_ff;
      if (ctrl.start) begin
         cre_in = '0;
         cim_in = '0;
         ex_in  = '0;
         er_in  = '0;
      end else if (pv_ff) begin
         cre_in = cre_ff + CW'(p_xrrr_ff) + CW'(p_xiri_ff);
         cim_in = cim_ff + CW'(p_xirr_ff) - CW'(p_xrri_ff);
         ex_in  = ex_ff + CW'(p_xrxr_ff) + CW'(p_xixi_ff);
         er_in  = er_ff + CW'(p_rrrr_ff) + CW'(p_riri_ff);
      end
      mag_re = cre_ff[CW-1] ? CW'(-cre_ff) : CW'(cre_ff);
      mag_im = cim_ff[CW-1] ? CW'(-cim_ff) : CW'(cim_ff);
      rhs    = CMPW'(rlo_ff) + (CMPW'(rhi_ff) << CW);
   end

   always_ff @(posedge clock) begin
      p_xrrr_ff <= xr * rr;
      p_xiri_ff <= xi * ri;
      p_xirr_ff <= xi * rr;
      p_xrri_ff <= xr * ri;
      p_xrxr_ff <= xr * xr;
      p_xixi_ff <= xi * xi;
      p_rrrr_ff <= rr * rr;
      p_riri_ff <= ri * ri;
      cre_ff    <= cre_in;
      cim_ff    <= cim_in;
      ex_ff     <= ex_in;
      er_ff     <= er_in;
      cre2_ff   <= mag_re * mag_re;
      cim2_ff   <= mag_im * mag_im;
      exer_ff   <= $unsigned(ex_ff) * $unsigned(er_ff);
      tt_ff     <= threshold * threshold;
      zero_ff   <= (ex_ff == '0) || (er_ff == '0);
      lhs_ff    <= (CMPW'(cre2_ff) + CMPW'(cim2_ff)) << ppd_pkg::SCALE_SHIFT;
      rlo_ff    <= exer_ff[CW-1:0] * tt_ff;
      rhi_ff    <= exer_ff[2*CW-1:CW] * tt_ff;
   end

   assign stat.done = (state_ff == CS_CMP);
   assign stat.hit  = !zero_ff && (lhs_ff > rhs);

endmodule

FILE: src/preamble_detect_ofdm_symbol_slicer.sv
// Top level: handshakes, config registers, frame slicer and the correlator ring.
// Timing: a result is registered from its transaction; a search sample with a full window
//   waits for the ring sweep through the MAC head and the drain, square, scale and compare.
// Throughput: one transaction per cycle outside the search unless the response stalls;
//   with a full window, the search takes no new sample until the single MAC head's verdict.
// Reset: synchronous, active high; clears window, counters, phase and config to defaults.
module preamble_detect_ofdm_symbol_slicer #(
   parameter int REF_LEN     = ppd_pkg::REF_LEN_DEFAULT,
   parameter int SAMPLE_BITS = ppd_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   ppd_req_if.sink                            req_bus,
   ppd_rsp_if.source                          rsp_bus,
   input  logic                               csr_write_en,
   input  logic [ppd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppd_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int FILLW = $clog2(REF_LEN + 1);

   typedef enum logic {ST_IDLE, ST_WAIT} state_type;
   typedef enum logic [1:0] {PH_SEARCH, PH_PREFIX, PH_DATA} phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic [ppd_pkg::SYM_BITS-1:0] sym_ff, sym_in;
   logic [ppd_pkg::SUB_BITS-1:0] cnt_ff, cnt_in;
   logic [FILLW-1:0]             fill_ff, fill_in;

   logic [ppd_pkg::THRESHOLD_BITS-1:0] thr_ff;
   logic [ppd_pkg::CP_BITS-1:0]        cp_ff;
   logic [ppd_pkg::SC_BITS-1:0]        sc_ff;
   logic [ppd_pkg::SPF_BITS-1:0]       spf_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          kind_ff, kind_in;
   logic [ppd_pkg::SYM_BITS-1:0]  osym_ff, osym_in;
   logic [ppd_pkg::SUB_BITS-1:0]  osub_ff, osub_in;
   logic signed [SAMPLE_BITS-1:0] ore_ff, ore_in, oim_ff, oim_in;
   logic                          ls_ff, ls_in, lf_ff, lf_in;

   logic req_ready, accept, acc_sample, emit, ls, lf, res_valid;
   logic [ppd_pkg::SUB_BITS-1:0] emit_cnt;
   logic [ppd_pkg::SC_BITS-1:0]  sc_eff;
   logic [ppd_pkg::SPF_BITS-1:0] spf_eff;

   ppd_pkg::ctrl_type ctrl;
   ppd_pkg::stat_type stat;

   // input handshake
   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept     = req_bus.valid && req_ready;
   assign acc_sample = accept && (req_bus.operation == ppd_pkg::OP_SAMPLE);
   assign req_bus.ready = req_ready;

   assign ctrl.shift   = acc_sample;
   assign ctrl.coef_we = accept && (req_bus.operation == ppd_pkg::OP_COEF);
   assign ctrl.start   = acc_sample && (phase_ff == PH_SEARCH) &&
                         (fill_ff >= FILLW'(REF_LEN - 1));

   ppd_corr #(.REF_LEN(REF_LEN), .SAMPLE_BITS(SAMPLE_BITS)) u_corr (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample_re  (req_bus.sample_re),
      .sample_im  (req_bus.sample_im),
      .coef_index (req_bus.coef_index),
      .coef_re    (req_bus.coef_re),
      .coef_im    (req_bus.coef_im),
      .threshold  (thr_ff),
      .stat       (stat)
   );

   // clamped frame geometry
   always_comb begin
      if (sc_ff == '0) begin
         sc_eff = ppd_pkg::SC_BITS'(1);
      end else if (sc_ff > ppd_pkg::SC_MAX) begin
         sc_eff = ppd_pkg::SC_MAX;
      end else begin
         sc_eff = sc_ff;
      end
      spf_eff = (spf_ff == '0) ? ppd_pkg::SPF_BITS'(1) : spf_ff;
   end

   // slicer and result formation
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      sym_in    = sym_ff;
      cnt_in    = cnt_ff;
      fill_in   = fill_ff;
      emit      = 1'b0;
      emit_cnt  = cnt_ff;
      res_valid = 1'b0;
      kind_in   = kind_ff;
      osym_in   = osym_ff;
      osub_in   = osub_ff;
      ore_in    = ore_ff;
      oim_in    = oim_ff;
      ls_in     = ls_ff;
      lf_in     = lf_ff;
      ls = (ppd_pkg::SC_BITS'(emit_cnt) + 1'b1) >= sc_eff;
      lf = ls && ((5'(sym_ff) + 5'd1) >= 5'(spf_eff));

      if (acc_sample) begin
         fill_in = (fill_ff == FILLW'(REF_LEN)) ? fill_ff : fill_ff + 1'b1;
         unique case (phase_ff)
            PH_SEARCH: begin
               if (ctrl.start) begin
                  state_in = ST_WAIT;
               end
            end
            PH_PREFIX: begin
               if (cnt_ff < {1'b0, cp_ff}) begin
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  emit     = 1'b1;
                  emit_cnt = '0;
               end
            end
            PH_DATA: emit = 1'b1;
            default: phase_in = PH_SEARCH;
         endcase
         ls = (ppd_pkg::SC_BITS'(emit_cnt) + 1'b1) >= sc_eff;
         lf = ls && ((5'(sym_ff) + 5'd1) >= 5'(spf_eff));
         if (emit) begin
            res_valid = 1'b1;
            kind_in   = ppd_pkg::KIND_DATA;
            osym_in   = sym_ff;
            osub_in   = emit_cnt;
            ore_in    = req_bus.sample_re;
            oim_in    = req_bus.sample_im;
            ls_in     = ls;
            lf_in     = lf;
            if (ls) begin
               cnt_in = '0;
               if (lf) begin
                  phase_in = PH_SEARCH;
                  sym_in   = '0;
                  fill_in  = '0;
               end else begin
                  sym_in   = sym_ff + 1'b1;
                  phase_in = PH_PREFIX;
               end
            end else begin
               phase_in = PH_DATA;
               cnt_in   = emit_cnt + 1'b1;
            end
         end
      end

      // correlator verdict
      if ((state_ff == ST_WAIT) && stat.done) begin
         state_in = ST_IDLE;
         if (stat.hit) begin
            res_valid = 1'b1;
            kind_in   = ppd_pkg::KIND_DETECT;
            osym_in   = '0;
            osub_in   = '0;
            ore_in    = '0;
            oim_in    = '0;
            ls_in     = 1'b0;
            lf_in     = 1'b0;
            phase_in  = PH_PREFIX;
            sym_in    = '0;
            cnt_in    = '0;
         end
      end

      rsp_valid_in = res_valid ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   // state, counters and the result register; the payload has no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_SEARCH;
         sym_ff       <= '0;
         cnt_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sym_ff       <= sym_in;
         cnt_ff       <= cnt_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      osym_ff <= osym_in;
      osub_ff <= osub_in;
      ore_ff  <= ore_in;
      oim_ff  <= oim_in;
      ls_ff   <= ls_in;
      lf_ff   <= lf_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= ppd_pkg::THRESHOLD_RESET;
         cp_ff  <= ppd_pkg::CP_RESET;
         sc_ff  <= ppd_pkg::SC_RESET;
         spf_ff <= ppd_pkg::SPF_RESET;
      end else if (csr_write_en) begin
         unique case (ppd_pkg::csr_index_type'(csr_index))
            ppd_pkg::CSR_THRESHOLD: thr_ff <= csr_data[ppd_pkg::THRESHOLD_BITS-1:0];
            ppd_pkg::CSR_CP:        cp_ff  <= csr_data[ppd_pkg::CP_BITS-1:0];
            ppd_pkg::CSR_SC:        sc_ff  <= csr_data[ppd_pkg::SC_BITS-1:0];
            ppd_pkg::CSR_SPF:       spf_ff <= csr_data[ppd_pkg::SPF_BITS-1:0];
            default:                thr_ff <= thr_ff;
         endcase
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.kind             = kind_ff;
   assign rsp_bus.symbol_index     = osym_ff;
   assign rsp_bus.subcarrier_index = osub_ff;
   assign rsp_bus.out_re           = ore_ff;
   assign rsp_bus.out_im           = oim_ff;
   assign rsp_bus.last_in_symbol   = ls_ff;
   assign rsp_bus.last_in_frame    = lf_ff;

   // no new transaction while the correlator runs
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT) |-> !req_bus.ready)
      else $error("request taken during correlation");

   // verdict only arrives while waiting for it
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      stat.done |-> (state_ff == ST_WAIT))
      else $error("correlator verdict outside wait");

   // a hit yields a detection result next cycle
   a_hit_result: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_WAIT) && stat.done && stat.hit) |=>
      (rsp_valid_ff && (kind_ff == ppd_pkg::KIND_DETECT)))
      else $error("detection not reported");

   // search starts only in the search phase
   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (phase_ff == PH_SEARCH))
      else $error("search started outside search phase");

endmodule
